// ===== src/random_slot_pool_allocator_core_assert.svh =====
`ifndef RANDOM_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define RANDOM_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RSPA_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rspa check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RSPA_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rspa check failed");

`endif

// ===== src/rspa_pkg.sv =====
package rspa_pkg;

    localparam int SLOTS   = 64;
    localparam int ROW_W   = 8;
    localparam int ROWS    = SLOTS / ROW_W;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int LANE_AW = $clog2(ROW_W);
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SEED_W  = 32;

    localparam logic [1:0] MODE_ACQ  = 2'd0;
    localparam logic [1:0] MODE_RAND = 2'd1;
    localparam logic [1:0] MODE_REL  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_TAKEN     = 3'd2;
    localparam logic [2:0] ST_NOT_ACQ   = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_slot;
        logic [2:0]       status;
    } out_item_t;

endpackage

// ===== src/rspa_div.sv =====
module rspa_div import rspa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SEED_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(SEED_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SEED_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  rem_next;

    // restoring remainder, one dividend bit per cycle, msb first
    always_comb
    begin
        trial = {rem_reg, dvd_reg[SEED_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = CNT_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SEED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SEED_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/random_slot_pool_allocator_core.sv =====
// named acquire or release: S_NAMED checks and updates the row, S_OUT loads the result, then S_IDLE accepts again
// random acquire: a count scan over the rows, a bit-serial remainder of the next seed and a select scan;
//   no free slot answers after the count scan alone
// one item is in flight at a time; the output register frees the input side early
// reset (rst_n, async, active low): every slot free, seed 1, pool size 64;
//   row valid bits make the used-bit memory read as zero, no clearing pass
`include "random_slot_pool_allocator_core_assert.svh"

module random_slot_pool_allocator_core import rspa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NAMED  = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_SELECT = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [LANE_AW:0] popcount(input logic [ROW_W-1:0] v);
        logic [LANE_AW:0] c;
        c = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            c = c + (LANE_AW + 1)'(v[j]);
        end
        return c;
    endfunction

    // lanes of a row that fall below the active pool size
    function automatic logic [ROW_W-1:0] lane_mask(input logic [ROW_AW-1:0] r,
                                                    input logic [SIZE_W-1:0] sz);
        logic [ROW_W-1:0] m;
        logic [IDX_W-1:0] slot;
        for (int j = 0; j < ROW_W; j++)
        begin
            slot = {r, LANE_AW'(j)};
            m[j] = ({1'b0, slot} < sz);
        end
        return m;
    endfunction

    // position of the n-th set bit, counting from zero
    function automatic logic [LANE_AW-1:0] nth_set(input logic [ROW_W-1:0] v,
                                                    input logic [LANE_AW-1:0] n);
        logic [LANE_AW:0]   seen;
        logic [LANE_AW-1:0] pos;
        logic               hit;
        seen = '0;
        pos  = '0;
        hit  = 1'b0;
        for (int j = 0; j < ROW_W; j++)
        begin
            if (v[j] && !hit && (seen == {1'b0, n}))
            begin
                pos = LANE_AW'(j);
                hit = 1'b1;
            end
            seen = seen + (LANE_AW + 1)'(v[j]);
        end
        return pos;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   pool_size_reg;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic [SEED_W-1:0]   seed_cand_reg, seed_cand_next;
    logic [1:0]          mode_reg, mode_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    out_item_t           res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    logic [ROW_AW:0]     iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]    pick_reg, pick_next;
    logic [ROWS-1:0]     row_vld_reg;
    logic                rd_pend_reg;
    logic                rd_vld_reg;
    logic [ROW_AW-1:0]   rd_row_reg;
    logic [ROW_W-1:0]    rd_data_reg;

    logic [ROW_W-1:0]    mem [ROWS];
    logic                mem_re;
    logic [ROW_AW-1:0]   mem_raddr;
    logic                mem_we;
    logic [ROW_AW-1:0]   mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;

    logic [SIZE_W-1:0]   size;
    logic [ROW_W-1:0]    row_q;
    logic [ROW_W-1:0]    free_bits;
    logic [LANE_AW:0]    row_free;
    logic [LANE_AW-1:0]  pick_lane;
    logic [LANE_AW-1:0]  lane;
    logic [ROW_AW-1:0]   row_sel;
    logic [CNT_W-1:0]    cnt_sum;
    logic                last_row;
    logic                div_start;
    logic                div_done;
    logic [CNT_W-1:0]    div_rem;

    assign size      = (pool_size_reg > SIZE_W'(SLOTS)) ? SIZE_W'(SLOTS) : pool_size_reg;
    assign row_q     = rd_vld_reg ? rd_data_reg : '0;
    assign free_bits = ~row_q & lane_mask(rd_row_reg, size);
    assign row_free  = popcount(free_bits);
    assign pick_lane = nth_set(free_bits, pick_reg[LANE_AW-1:0]);
    assign lane      = idx_reg[LANE_AW-1:0];
    assign row_sel   = idx_reg[IDX_W-1:LANE_AW];
    assign cnt_sum   = free_cnt_reg + CNT_W'(row_free);
    assign last_row  = (rd_row_reg == ROW_AW'(ROWS - 1));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rspa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (xorshift(seed_reg)),
        .divisor   (cnt_sum),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        seed_cand_next = seed_cand_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        iss_cnt_next   = iss_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = iss_cnt_reg[ROW_AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = row_sel;
        mem_wdata      = row_q;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = in_data.mode;
                    idx_next  = in_data.slot_index;
                    mem_re    = 1'b1;
                    mem_raddr = in_data.slot_index[IDX_W-1:LANE_AW];
                    case (in_data.mode) inside
                        MODE_ACQ, MODE_REL:
                        begin
                            if ({1'b0, in_data.slot_index} < size)
                            begin
                                state_next = S_NAMED;
                            end
                            else
                            begin
                                res_next   = '{granted_slot: '0, status: ST_RANGE};
                                state_next = S_OUT;
                            end
                        end
                        MODE_RAND:
                        begin
                            // the count scan starts here with row 0
                            mem_raddr     = '0;
                            iss_cnt_next  = (ROW_AW + 1)'(1);
                            free_cnt_next = '0;
                            state_next    = S_COUNT;
                        end
                        default:
                        begin
                            res_next   = '{granted_slot: '0, status: ST_RANGE};
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_NAMED:
            begin
                state_next = S_OUT;
                if (mode_reg == MODE_ACQ)
                begin
                    if (row_q[lane])
                    begin
                        res_next = '{granted_slot: '0, status: ST_TAKEN};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = row_q | (ROW_W'(1) << lane);
                        res_next  = '{granted_slot: idx_reg, status: ST_OK};
                    end
                end
                else
                begin
                    if (!row_q[lane])
                    begin
                        res_next = '{granted_slot: '0, status: ST_NOT_ACQ};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = row_q & ~(ROW_W'(1) << lane);
                        res_next  = '{granted_slot: idx_reg, status: ST_OK};
                    end
                end
            end
            S_COUNT:
            begin
                if (iss_cnt_reg < (ROW_AW + 1)'(ROWS))
                begin
                    mem_re       = 1'b1;
                    iss_cnt_next = iss_cnt_reg + (ROW_AW + 1)'(1);
                end
                if (rd_pend_reg)
                begin
                    free_cnt_next = cnt_sum;
                    if (last_row)
                    begin
                        if (cnt_sum == '0)
                        begin
                            res_next   = '{granted_slot: '0, status: ST_EXHAUSTED};
                            state_next = S_OUT;
                        end
                        else
                        begin
                            seed_cand_next = xorshift(seed_reg);
                            div_start      = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pick_next    = div_rem;
                    iss_cnt_next = '0;
                    state_next   = S_SELECT;
                end
            end
            S_SELECT:
            begin
                if (iss_cnt_reg < (ROW_AW + 1)'(ROWS))
                begin
                    mem_re       = 1'b1;
                    iss_cnt_next = iss_cnt_reg + (ROW_AW + 1)'(1);
                end
                if (rd_pend_reg)
                begin
                    if (pick_reg < CNT_W'(row_free))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = rd_row_reg;
                        mem_wdata  = row_q | (ROW_W'(1) << pick_lane);
                        seed_next  = seed_cand_reg;
                        res_next   = '{granted_slot: {rd_row_reg, pick_lane}, status: ST_OK};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pick_next = pick_reg - CNT_W'(row_free);
                        if (last_row)
                        begin
                            res_next   = '{granted_slot: '0, status: ST_EXHAUSTED};
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_size_reg <= SIZE_W'(SLOTS);
            seed_reg      <= SEED_W'(1);
            out_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
            row_vld_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
            rd_pend_reg   <= mem_re;
            if (mem_re)
            begin
                rd_vld_reg <= row_vld_reg[mem_raddr];
            end
            if (mem_we)
            begin
                row_vld_reg[mem_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seed_cand_reg <= seed_cand_next;
        mode_reg      <= mode_next;
        idx_reg       <= idx_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
        free_cnt_reg  <= free_cnt_next;
        pick_reg      <= pick_next;
        if (mem_re)
        begin
            rd_row_reg <= mem_raddr;
        end
    end

    // used-bit rows, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `RSPA_IMPLY(a_we_in_update, mem_we, (state_reg == S_NAMED) || (state_reg == S_SELECT))
    `RSPA_IMPLY(a_seed_on_pick, !$stable(seed_reg), $past(state_reg) == S_SELECT)
    `RSPA_NEXT(a_out_load, (state_reg == S_OUT) && (!out_valid_reg || out_ready), out_valid_reg && (state_reg == S_IDLE))
    `RSPA_IMPLY(a_err_slot_zero, out_valid_reg && (out_data_reg.status != ST_OK), out_data_reg.granted_slot == '0)

endmodule
